// ----- rtl/hpp_lattice_gas_step_macros.svh -----
// Assertion macros used by the lattice gas top level.
`ifndef HPP_LATTICE_GAS_STEP_MACROS_SVH
`define HPP_LATTICE_GAS_STEP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HPP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hpp_pkg.sv -----
// Types and constants shared by the lattice gas modules.
`timescale 1ns / 1ps

package hpp_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam logic [6:0] GRID_RESET = 7'd64;

    localparam int CELL_W = 5;
    localparam int BIT_N  = 0;
    localparam int BIT_E  = 1;
    localparam int BIT_S  = 2;
    localparam int BIT_W  = 3;
    localparam int BIT_WALL = 4;

    localparam logic [3:0] DIRS_NS = 4'b0101;
    localparam logic [3:0] DIRS_EW = 4'b1010;

    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    typedef logic [CELL_W-1:0] t_cell;

    typedef enum logic [2:0] {
        ACT_WRITE   = 3'd0,
        ACT_READ    = 3'd1,
        ACT_COLLIDE = 3'd2,
        ACT_STREAM  = 3'd3,
        ACT_CLEAR   = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SWEEP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic in_grid;
        logic n_in;
        logic s_in;
        logic e_in;
        logic w_in;
    } t_edges;

endpackage

// ----- rtl/hpp_lattice_gas_step.sv -----
// Top level of the HPP lattice gas grid with its sweep engine and ports.
`timescale 1ns / 1ps
`include "hpp_lattice_gas_step_macros.svh"

// The grid lives in one on-chip memory. Items arrive on the s_axis channel with the
// action in tuser and the cell coordinates and write data in tdata. Every item gives
// exactly one result on m_axis; only a read returns nonzero data.
// A write, a read or an unknown action moves to the done state, which then puts its result
// in the output register. Collide, stream and clear sweep the whole memory through a chain
// of 2*2^XW+1 cell stages, one cell per cycle, and go to the done state after the last cell.
// The sweep length is set by the single memory read port feeding the chain.
// One item is worked on at a time; the next item is accepted as soon as the previous
// result sits in the output register, even if the receiver has not taken it yet.
// After reset the memory is cleared one entry per cycle, all MAX_HEIGHT*2^XW entries
// (4096 at the default), during which s_axis_tready stays low; configuration writes are
// taken at any time. When the receiver stalls, the result holds in the output register
// and a finished item waits before the next one is accepted.
// Configuration is an APB port with grid_width at 0x0 and grid_height at 0x4.
module hpp_lattice_gas_step
    import hpp_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cell_x[5:0], cell_y[11:6], in_wall[12], in_dirs[16:13], zero[23:17]
    input  logic [23:0] s_axis_tdata,
    // action[2:0]
    input  logic [2:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_wall[0], out_dirs[4:1], zero[7:5]
    output logic [7:0]  m_axis_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int PITCH = 1 << XW;
    localparam int NCELL = MAX_HEIGHT * PITCH;
    localparam int CHAIN = 2 * PITCH + 1;
    localparam int LEAD  = PITCH + 2;
    localparam int LAST  = NCELL + PITCH + 1;
    localparam int CNTW  = $clog2(LAST + 1);
    localparam int CMPX  = (XW + 1 > 7) ? XW + 1 : 7;
    localparam int CMPW  = (YW + 1 > CMPX) ? YW + 1 : CMPX;

    t_state r_state;
    t_state n_state;

    logic [6:0] r_grid_width;
    logic [6:0] r_grid_height;

    logic [CNTW-1:0] r_cnt;
    logic [CNTW-1:0] n_cnt;

    t_action r_act;
    logic    r_inside;
    logic [AW-1:0] r_addr;

    logic  r_out_valid;
    t_cell r_out_cell;

    t_cell r_mem [1 << AW];
    t_cell r_rdata;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_cell         w_wdata;
    logic [AW-1:0] w_raddr;
    logic          w_shift;
    logic          w_out_load;
    logic          w_cfg_wr;

    logic          w_in_acc;
    t_action       w_in_act;
    logic          w_in_sweep;
    logic [15:0]   w_in_x16;
    logic [15:0]   w_in_y16;
    logic [AW-1:0] w_in_addr;
    logic          w_in_inside;

    logic [CMPW-1:0] w_weff;
    logic [CMPW-1:0] w_heff;
    logic [CMPW-1:0] w_gw;
    logic [CMPW-1:0] w_gh;

    logic [CNTW-1:0] w_ca_full;
    logic [AW-1:0]   w_ca;
    logic            w_ctr_ok;
    logic [CMPW-1:0] w_cx;
    logic [CMPW-1:0] w_cy;
    t_edges          w_edge;
    t_cell           w_rule_out;
    t_cell           w_tap [CHAIN];

    // Effective grid size, clamped to the memory.
    assign w_gw   = CMPW'(r_grid_width);
    assign w_gh   = CMPW'(r_grid_height);
    assign w_weff = (w_gw > CMPW'(MAX_WIDTH)) ? CMPW'(MAX_WIDTH) : w_gw;
    assign w_heff = (w_gh > CMPW'(MAX_HEIGHT)) ? CMPW'(MAX_HEIGHT) : w_gh;

    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign w_in_act    = t_action'(s_axis_tuser);
    assign w_in_sweep  = (w_in_act inside {ACT_COLLIDE, ACT_STREAM, ACT_CLEAR});
    assign w_in_x16    = 16'(s_axis_tdata[5:0]);
    assign w_in_y16    = 16'(s_axis_tdata[11:6]);
    assign w_in_addr   = {w_in_y16[YW-1:0], w_in_x16[XW-1:0]};
    assign w_in_inside = (CMPW'(s_axis_tdata[5:0]) < w_weff)
                      && (CMPW'(s_axis_tdata[11:6]) < w_heff);

    // Cell at the center of the chain and its position in the grid.
    assign w_ca_full = r_cnt - CNTW'(LEAD);
    assign w_ca      = w_ca_full[AW-1:0];
    assign w_ctr_ok  = (r_cnt >= CNTW'(LEAD));
    assign w_cx      = CMPW'(w_ca[XW-1:0]);
    assign w_cy      = CMPW'(w_ca[AW-1:XW]);

    assign w_edge.in_grid = (w_cx < w_weff) && (w_cy < w_heff);
    assign w_edge.n_in    = (w_cy + CMPW'(1)) < w_heff;
    assign w_edge.s_in    = (w_cy != '0);
    assign w_edge.e_in    = (w_cx + CMPW'(1)) < w_weff;
    assign w_edge.w_in    = (w_cx != '0);

    genvar g;
    generate
        for (g = 0; g < CHAIN; g++) begin : g_chain
            if (g == 0) begin : g_head
                hpp_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_shift),
                    .i_d     (r_rdata),
                    .o_q     (w_tap[g])
                );
            end else begin : g_body
                hpp_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_shift),
                    .i_d     (w_tap[g-1]),
                    .o_q     (w_tap[g])
                );
            end
        end
    endgenerate

    hpp_rule u_rule (
        .i_act  (r_act),
        .i_c    (w_tap[PITCH]),
        .i_n    (w_tap[0]),
        .i_s    (w_tap[2*PITCH]),
        .i_e    (w_tap[PITCH-1]),
        .i_w    (w_tap[PITCH+1]),
        .i_edge (w_edge),
        .o_cell (w_rule_out)
    );

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (r_cnt == CNTW'(NCELL - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_in_sweep ? ST_SWEEP : ST_DONE;
                end
            end
            ST_SWEEP: begin
                if (r_cnt == CNTW'(LAST)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_out_load    = 1'b0;
        w_shift       = 1'b0;
        w_we          = 1'b0;
        w_waddr       = r_addr;
        w_wdata       = '0;
        w_raddr       = r_addr;
        n_cnt         = r_cnt;
        case (r_state)
            ST_INIT: begin
                w_we    = 1'b1;
                w_waddr = r_cnt[AW-1:0];
                n_cnt   = r_cnt + CNTW'(1);
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                w_raddr = w_in_addr;
                w_waddr = w_in_addr;
                w_wdata = {s_axis_tdata[12], s_axis_tdata[16:13]};
                w_we    = w_in_acc && (w_in_act == ACT_WRITE) && w_in_inside;
                n_cnt   = '0;
            end
            ST_SWEEP: begin
                w_shift = 1'b1;
                w_raddr = r_cnt[AW-1:0];
                w_waddr = w_ca;
                w_wdata = w_rule_out;
                w_we    = w_ctr_ok && w_edge.in_grid;
                n_cnt   = r_cnt + CNTW'(1);
            end
            ST_DONE: begin
                w_out_load = !r_out_valid || m_axis_tready;
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_INIT;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
            r_grid_width  <= GRID_RESET;
            r_grid_height <= GRID_RESET;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_wr) begin
                if (paddr[2] == REG_GRID_WIDTH) begin
                    r_grid_width <= pwdata[6:0];
                end else begin
                    r_grid_height <= pwdata[6:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_act    <= w_in_act;
            r_inside <= w_in_inside;
            r_addr   <= w_in_addr;
        end
        if (w_out_load) begin
            r_out_cell <= ((r_act == ACT_READ) && r_inside) ? r_rdata : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_cell[3:0], r_out_cell[BIT_WALL]};

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GRID_WIDTH) ? {25'd0, r_grid_width}
                                                 : {25'd0, r_grid_height};

    `HPP_ASSERT_NOW(a_sweep_write_in_grid, w_we && (r_state == ST_SWEEP),
        (w_cx < w_weff) && (w_cy < w_heff), "sweep wrote a cell outside the grid")
    `HPP_ASSERT_NOW(a_sweep_count_bound, r_state == ST_SWEEP, r_cnt <= CNTW'(LAST),
        "sweep counter ran past the last cell")
    `HPP_ASSERT_NEXT(a_sweep_ends, (r_state == ST_SWEEP) && (r_cnt == CNTW'(LAST)),
        r_state == ST_DONE, "sweep did not finish after the last cell")
    `HPP_ASSERT_NEXT(a_single_done, w_in_acc && !w_in_sweep, r_state == ST_DONE,
        "single cell item did not move to result stage")

endmodule

// ----- rtl/hpp_cell.sv -----
// One stage of the cell chain that carries grid cells past the update rule.
`timescale 1ns / 1ps

module hpp_cell
    import hpp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_shift,
    input  t_cell i_d,
    output t_cell o_q
);

    t_cell r_q;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// ----- rtl/hpp_rule.sv -----
// Collide, stream and clear rule for the cell at the center of the chain.
`timescale 1ns / 1ps

module hpp_rule
    import hpp_pkg::*;
(
    input  t_action i_act,
    input  t_cell   i_c,
    input  t_cell   i_n,
    input  t_cell   i_s,
    input  t_cell   i_e,
    input  t_cell   i_w,
    input  t_edges  i_edge,
    output t_cell   o_cell
);

    logic w_n_open;
    logic w_s_open;
    logic w_e_open;
    logic w_w_open;
    logic [3:0] w_flow;

    assign w_n_open = i_edge.n_in && !i_n[BIT_WALL];
    assign w_s_open = i_edge.s_in && !i_s[BIT_WALL];
    assign w_e_open = i_edge.e_in && !i_e[BIT_WALL];
    assign w_w_open = i_edge.w_in && !i_w[BIT_WALL];

    // A particle either arrives from the open neighbor or bounces back from a blocked side.
    assign w_flow[BIT_N] = (w_s_open && i_s[BIT_N]) || (!w_s_open && i_c[BIT_S]);
    assign w_flow[BIT_S] = (w_n_open && i_n[BIT_S]) || (!w_n_open && i_c[BIT_N]);
    assign w_flow[BIT_E] = (w_w_open && i_w[BIT_E]) || (!w_w_open && i_c[BIT_W]);
    assign w_flow[BIT_W] = (w_e_open && i_e[BIT_W]) || (!w_e_open && i_c[BIT_E]);

    always_comb begin
        o_cell = i_c;
        case (i_act)
            ACT_CLEAR: begin
                o_cell = {i_c[BIT_WALL], 4'b0000};
            end
            ACT_COLLIDE: begin
                if (!i_c[BIT_WALL]) begin
                    if (i_c[3:0] == DIRS_NS) begin
                        o_cell = {1'b0, DIRS_EW};
                    end else if (i_c[3:0] == DIRS_EW) begin
                        o_cell = {1'b0, DIRS_NS};
                    end
                end
            end
            ACT_STREAM: begin
                if (!i_c[BIT_WALL]) begin
                    o_cell = {1'b0, w_flow};
                end
            end
            default: begin
                o_cell = i_c;
            end
        endcase
    end

endmodule
